/* hw/rtl/imhq_pkg.sv */
package imhq_pkg;

  localparam int DEPTH_DEF    = 256;
  localparam int KEY_BITS_DEF = 32;
  localparam int ID_COUNT_DEF = 256;
  localparam int CAP_RESET    = 256;

  typedef enum logic [2:0] {
    ACT_PUSH     = 3'd0,
    ACT_POP      = 3'd1,
    ACT_PEEK     = 3'd2,
    ACT_ADJUST   = 3'd3,
    ACT_ERASE    = 3'd4,
    ACT_CONTAINS = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_EMPTY       = 2'd2,
    ST_NOT_PRESENT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_POP0,
    S_POP1,
    S_ER1,
    S_RS_RD,
    S_RS_CMP,
    S_DN1,
    S_DN2,
    S_DN3,
    S_PLACE,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  node_id;
    logic [31:0] node_key;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_id;
    logic [31:0] out_key;
    logic        is_present;
    logic [8:0]  entry_count;
  } out_word_t;

endpackage

/* hw/rtl/indexed_min_heap_queue_top.sv */
// channel | direction | handshake          | word
// in      | input     | in_valid/in_stall   | in_word  (action, node_id, node_key)
// out     | output    | out_valid/out_stall | out_word (status, ids, key, count)
// cfg     | input     | apb, pready tied 1  | capacity at byte address 0
// each word runs through a sequencer that drives the slot memory, the position
// memory and the key comparisons: a lookup, then a parent read and compare per level
// going up, or a left child read, right child read and compare per level going down,
// plus place and finish.
// rst_n is synchronous; it empties the heap and restores capacity, no clearing pass.
// a finished word waits in the output register while the next word is accepted.
module indexed_min_heap_queue_top
  import imhq_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF,
  parameter int ID_COUNT = ID_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IW  = $clog2(DEPTH);
  localparam int SW  = $clog2(DEPTH + 1);
  localparam int CHW = IW + 2;
  localparam int IDW = $clog2(ID_COUNT);
  localparam int KW  = KEY_BITS;
  localparam int EW  = IDW + KW;

  seq_state_t state_r, state_nxt;
  logic [2:0]     act_r;
  logic [IDW-1:0] idx_r;
  logic           id_ok_r;
  logic [KW-1:0]  key_r;
  logic [IDW-1:0] item_id_r, item_id_nxt;
  logic [KW-1:0]  item_key_r, item_key_nxt;
  logic [IW-1:0]  hole_r, hole_nxt;
  logic [SW-1:0]  cnt_r, cnt_nxt;
  logic [8:0]     cap_r;
  logic           up_r, up_nxt;
  logic           rem_r, rem_nxt;
  logic [IDW-1:0] rem_id_r, rem_id_nxt;
  logic [EW-1:0]  lft_r, lft_nxt;
  logic [1:0]     res_status_r, res_status_nxt;
  logic [7:0]     res_id_r, res_id_nxt;
  logic [31:0]    res_key_r, res_key_nxt;
  logic           res_pres_r, res_pres_nxt;
  out_word_t      out_word_r;
  logic           out_valid_r;
  logic           out_load;

  logic [EW-1:0]  slot_mem [DEPTH];
  logic           slot_we;
  logic [IW-1:0]  slot_wa, slot_ra;
  logic [EW-1:0]  slot_wd, slot_rd_r;
  logic [IW-1:0]  pos_mem [ID_COUNT];
  logic           pos_we;
  logic [IDW-1:0] pos_wa, pos_ra;
  logic [IW-1:0]  pos_wd, pos_rd_r;
  logic [ID_COUNT-1:0] vld_r, vld_nxt;
  logic           vld_clr;

  logic           accept;
  logic [15:0]    in_id16;
  logic [63:0]    in_key64;
  logic           pres;
  logic [15:0]    limit;
  logic [IW-1:0]  parent;
  logic [CHW-1:0] child;
  logic [CHW-1:0] cnt_ext;
  logic           take_right;
  logic [EW-1:0]  chosen;
  logic [IW-1:0]  chosen_idx;
  logic [63:0]    rd_key64;
  logic [15:0]    rd_id16;
  logic [15:0]    cnt16;

  assign in_stall   = (state_r != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign in_id16    = 16'(in_word.node_id);
  assign in_key64   = 64'(in_word.node_key);
  assign out_valid  = out_valid_r;
  assign out_word   = out_word_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = 32'(cap_r);

  assign limit   = (16'(cap_r) < 16'(DEPTH)) ? 16'(cap_r) : 16'(DEPTH);
  assign pres    = id_ok_r && vld_r[idx_r] && (SW'(pos_rd_r) < cnt_r);
  assign parent  = IW'((hole_r - IW'(1)) >> 1);
  assign child   = {1'b0, hole_r, 1'b0} + CHW'(2);
  assign cnt_ext = CHW'(cnt_r);
  // on equal keys the right child is taken
  assign take_right = (child < cnt_ext) &&
                      !(lft_r[KW-1:0] < slot_rd_r[KW-1:0]);
  assign chosen     = take_right ? slot_rd_r : lft_r;
  assign chosen_idx = take_right ? IW'(child) : IW'(child - CHW'(1));
  assign rd_key64   = 64'(slot_rd_r[KW-1:0]);
  assign rd_id16    = 16'(slot_rd_r[EW-1:KW]);
  assign cnt16      = 16'(cnt_r);

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd_r <= slot_mem[slot_ra];
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    pos_rd_r <= pos_mem[pos_ra];
  end

  always_comb begin
    vld_nxt = vld_r;
    if (pos_we) begin
      vld_nxt[pos_wa] = 1'b1;
    end
    // removed id is dropped after its last placement
    if (vld_clr) begin
      vld_nxt[rem_id_r] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cap_r       <= 9'(CAP_RESET);
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
        cap_r <= cfg_pwdata[8:0];
      end
      vld_r <= vld_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= in_word.action;
      idx_r   <= in_id16[IDW-1:0];
      id_ok_r <= (32'(in_word.node_id) < ID_COUNT);
      key_r   <= in_key64[KW-1:0];
    end
    item_id_r    <= item_id_nxt;
    item_key_r   <= item_key_nxt;
    hole_r       <= hole_nxt;
    up_r         <= up_nxt;
    rem_r        <= rem_nxt;
    rem_id_r     <= rem_id_nxt;
    lft_r        <= lft_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_key_r    <= res_key_nxt;
    res_pres_r   <= res_pres_nxt;
    if (out_load) begin
      out_word_r.status      <= res_status_r;
      out_word_r.out_id      <= res_id_r;
      out_word_r.out_key     <= res_key_r;
      out_word_r.is_present  <= res_pres_r;
      out_word_r.entry_count <= cnt16[8:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    item_id_nxt    = item_id_r;
    item_key_nxt   = item_key_r;
    hole_nxt       = hole_r;
    up_nxt         = up_r;
    rem_nxt        = rem_r;
    rem_id_nxt     = rem_id_r;
    lft_nxt        = lft_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_key_nxt    = res_key_r;
    res_pres_nxt   = res_pres_r;
    slot_we        = 1'b0;
    slot_wa        = hole_r;
    slot_wd        = {item_id_r, item_key_r};
    slot_ra        = '0;
    pos_we         = 1'b0;
    pos_wa         = item_id_r;
    pos_wd         = hole_r;
    pos_ra         = in_id16[IDW-1:0];
    vld_clr        = 1'b0;
    out_load       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          rem_nxt        = 1'b0;
          up_nxt         = 1'b0;
          res_status_nxt = ST_OK;
          res_id_nxt     = '0;
          res_key_nxt    = '0;
          res_pres_nxt   = 1'b0;
          state_nxt      = S_DISP;
        end
      end
      S_DISP: begin
        item_id_nxt  = idx_r;
        item_key_nxt = key_r;
        state_nxt    = S_DONE;
        case (act_r)
          ACT_PUSH: begin
            if (!id_ok_r) begin
              res_status_nxt = ST_NOT_PRESENT;
            end else if (pres) begin
              hole_nxt  = pos_rd_r;
              state_nxt = S_RS_RD;
            end else if (16'(cnt_r) >= limit) begin
              res_status_nxt = ST_FULL;
            end else begin
              hole_nxt  = IW'(cnt_r);
              cnt_nxt   = cnt_r + SW'(1);
              state_nxt = S_RS_RD;
            end
          end
          ACT_POP, ACT_PEEK: begin
            if (cnt_r == '0) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              slot_ra   = '0;
              state_nxt = S_POP0;
            end
          end
          ACT_ADJUST: begin
            if (!pres) begin
              res_status_nxt = ST_NOT_PRESENT;
            end else begin
              hole_nxt  = pos_rd_r;
              state_nxt = S_RS_RD;
            end
          end
          ACT_ERASE: begin
            if (!pres) begin
              res_status_nxt = ST_NOT_PRESENT;
            end else begin
              cnt_nxt    = cnt_r - SW'(1);
              slot_ra    = IW'(cnt_r - SW'(1));
              hole_nxt   = pos_rd_r;
              rem_nxt    = 1'b1;
              rem_id_nxt = idx_r;
              state_nxt  = S_ER1;
            end
          end
          ACT_CONTAINS: begin
            res_pres_nxt = pres;
          end
          default: begin
          end
        endcase
      end
      S_POP0: begin
        res_id_nxt  = rd_id16[7:0];
        res_key_nxt = rd_key64[31:0];
        if (act_r == ACT_PEEK) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt    = cnt_r - SW'(1);
          slot_ra    = IW'(cnt_r - SW'(1));
          rem_nxt    = 1'b1;
          rem_id_nxt = slot_rd_r[EW-1:KW];
          hole_nxt   = '0;
          state_nxt  = S_POP1;
        end
      end
      S_POP1: begin
        item_id_nxt  = slot_rd_r[EW-1:KW];
        item_key_nxt = slot_rd_r[KW-1:0];
        state_nxt    = S_DN1;
      end
      S_ER1: begin
        item_id_nxt  = slot_rd_r[EW-1:KW];
        item_key_nxt = slot_rd_r[KW-1:0];
        state_nxt    = S_RS_RD;
      end
      S_RS_RD: begin
        if (hole_r == '0) begin
          state_nxt = up_r ? S_PLACE : S_DN1;
        end else begin
          slot_ra   = parent;
          state_nxt = S_RS_CMP;
        end
      end
      S_RS_CMP: begin
        if (item_key_r < slot_rd_r[KW-1:0]) begin
          // parent moves down into the hole
          slot_we   = 1'b1;
          slot_wd   = slot_rd_r;
          pos_we    = 1'b1;
          pos_wa    = slot_rd_r[EW-1:KW];
          hole_nxt  = parent;
          up_nxt    = 1'b1;
          state_nxt = S_RS_RD;
        end else begin
          state_nxt = up_r ? S_PLACE : S_DN1;
        end
      end
      S_DN1: begin
        if (child > cnt_ext) begin
          state_nxt = S_PLACE;
        end else begin
          slot_ra   = IW'(child - CHW'(1));
          state_nxt = S_DN2;
        end
      end
      S_DN2: begin
        lft_nxt = slot_rd_r;
        if (child < cnt_ext) begin
          slot_ra = IW'(child);
        end
        state_nxt = S_DN3;
      end
      S_DN3: begin
        if (item_key_r < chosen[KW-1:0]) begin
          state_nxt = S_PLACE;
        end else begin
          slot_we   = 1'b1;
          slot_wd   = chosen;
          pos_we    = 1'b1;
          pos_wa    = chosen[EW-1:KW];
          hole_nxt  = chosen_idx;
          state_nxt = S_DN1;
        end
      end
      S_PLACE: begin
        slot_we   = 1'b1;
        pos_we    = 1'b1;
        vld_clr   = rem_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* test/heap_checker.sv */
`timescale 1ns / 1ps
module heap_checker
  import imhq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_word,
  input  logic      cfg_we,
  input  logic [8:0] cfg_cap,
  output int        fail_count,
  output int        pending
);
  localparam int NSLOT = 256;
  localparam logic [8:0] ABSENT = 9'd256;

  logic [31:0] heap_key [NSLOT];
  logic [7:0]  heap_id  [NSLOT];
  logic [8:0]  where_is [NSLOT];
  int unsigned live;
  logic [8:0]  cap_limit;
  out_word_t   expected_q [$];

  function automatic void place(int unsigned slot, logic [7:0] id, logic [31:0] key);
    heap_key[slot] = key;
    heap_id[slot] = id;
    where_is[id] = slot[8:0];
  endfunction

  function automatic void bubble_up(int unsigned hole, logic [7:0] id, logic [31:0] key,
                                    bit forced);
    int unsigned up;
    while (hole > 0) begin
      up = (hole - 1) / 2;
      if (!forced && !(key < heap_key[up])) break;
      forced = 0;
      place(hole, heap_id[up], heap_key[up]);
      hole = up;
    end
    place(hole, id, key);
  endfunction

  function automatic void bubble_down(int unsigned hole, logic [7:0] id, logic [31:0] key);
    int unsigned kid;
    kid = 2 * hole + 2;
    while (kid <= live) begin
      if (kid == live || heap_key[kid-1] < heap_key[kid]) kid--;
      if (key < heap_key[kid]) break;
      place(hole, heap_id[kid], heap_key[kid]);
      hole = kid;
      kid = 2 * hole + 2;
    end
    place(hole, id, key);
  endfunction

  function automatic void reseat(int unsigned pos, logic [7:0] id, logic [31:0] key);
    if (pos > 0 && key < heap_key[(pos - 1) / 2]) bubble_up(pos, id, key, 1);
    else bubble_down(pos, id, key);
  endfunction

  function automatic bit holds(logic [7:0] id);
    return where_is[id] < live;
  endfunction

  function automatic out_word_t apply_word(in_word_t w);
    out_word_t r;
    int unsigned pos;
    r = '0;
    r.status = ST_OK;
    case (w.action)
      ACT_PUSH: begin
        if (holds(w.node_id)) reseat(where_is[w.node_id], w.node_id, w.node_key);
        else if (live >= ((cap_limit < ABSENT) ? cap_limit : ABSENT)) r.status = ST_FULL;
        else begin
          live++;
          bubble_up(live - 1, w.node_id, w.node_key, 0);
        end
      end
      ACT_POP, ACT_PEEK: begin
        if (live == 0) r.status = ST_EMPTY;
        else begin
          r.out_id = heap_id[0];
          r.out_key = heap_key[0];
          if (w.action == ACT_POP) begin
            live--;
            bubble_down(0, heap_id[live], heap_key[live]);
            where_is[r.out_id] = ABSENT;
          end
        end
      end
      ACT_ADJUST: begin
        if (!holds(w.node_id)) r.status = ST_NOT_PRESENT;
        else reseat(where_is[w.node_id], w.node_id, w.node_key);
      end
      ACT_ERASE: begin
        if (!holds(w.node_id)) r.status = ST_NOT_PRESENT;
        else begin
          pos = where_is[w.node_id];
          live--;
          reseat(pos, heap_id[live], heap_key[live]);
          where_is[w.node_id] = ABSENT;
        end
      end
      ACT_CONTAINS: r.is_present = holds(w.node_id);
      default: ;
    endcase
    r.entry_count = live[8:0];
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) where_is[i] = ABSENT;
      live = 0;
      cap_limit = 9'd256;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we) cap_limit = cfg_cap;
      if (in_valid && !in_stall) expected_q.push_back(apply_word(in_word));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected word %p", out_word);
        end else begin
          e = expected_q.pop_front();
          if (out_word !== e) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("mismatch: expected %p, got %p", e, out_word);
          end
        end
      end
    end
  end
endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import imhq_pkg::*;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  in_word_t in_word = '0;
  out_word_t out_word;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0, cfg_prdata;
  logic cfg_pready;
  int fail_count, pending;
  int send_idle = 0, stall_pct = 0, quiet = 0;
  localparam int QUIET_LIMIT = 20000;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  indexed_min_heap_queue_top dut (.*);

  heap_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_word, .out_valid, .out_stall, .out_word,
    .cfg_we(cfg_psel && cfg_penable && cfg_pwrite && cfg_pready),
    .cfg_cap(cfg_pwdata[8:0]), .fail_count, .pending
  );

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_capacity(logic [8:0] v);
    @(negedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= '0; cfg_pwdata <= {23'd0, v};
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  // valid stays up after the accepting edge until the next falling edge decides
  task automatic send_word(action_t a, logic [7:0] id, logic [31:0] key);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_word <= '{action: a, node_id: id, node_key: key};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_key();
    case ($urandom_range(3))
      0: return $urandom_range(15);
      1: return 32'hFFFF_FFF0 | $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_words(int n, int id_span);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40) send_word(ACT_PUSH, 8'($urandom_range(id_span)), rand_key());
      else if (r < 55) send_word(ACT_POP, 8'($urandom), $urandom);
      else if (r < 63) send_word(ACT_PEEK, 8'($urandom), $urandom);
      else if (r < 75) send_word(ACT_ADJUST, 8'($urandom_range(id_span)), rand_key());
      else if (r < 87) send_word(ACT_ERASE, 8'($urandom_range(id_span)), $urandom);
      else if (r < 96) send_word(ACT_CONTAINS, 8'($urandom_range(id_span)), $urandom);
      else send_word(action_t'(3'd6 + $urandom_range(1)), 8'($urandom), $urandom);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1;
    // directed: empty heap, extremes, ties, every action, unused codes
    send_word(ACT_POP, 8'd0, 32'd0);
    send_word(ACT_PEEK, 8'd0, 32'd0);
    send_word(ACT_ERASE, 8'd9, 32'd0);
    send_word(ACT_ADJUST, 8'd255, 32'd1);
    send_word(ACT_PUSH, 8'd255, 32'hFFFF_FFFF);
    send_word(ACT_PUSH, 8'd0, 32'd0);
    send_word(ACT_PUSH, 8'd7, 32'd5);
    send_word(ACT_PUSH, 8'd8, 32'd5);
    send_word(ACT_PUSH, 8'd7, 32'd5);
    send_word(ACT_CONTAINS, 8'd255, 32'd0);
    send_word(ACT_CONTAINS, 8'd3, 32'd0);
    send_word(ACT_ADJUST, 8'd255, 32'd0);
    send_word(ACT_ADJUST, 8'd0, 32'hFFFF_FFFF);
    send_word(ACT_PEEK, 8'd0, 32'd0);
    send_word(ACT_ERASE, 8'd8, 32'd0);
    send_word(action_t'(3'd6), 8'hFF, 32'hFFFF_FFFF);
    send_word(action_t'(3'd7), 8'h00, 32'd0);
    send_word(ACT_POP, 8'd0, 32'd0);
    send_word(ACT_POP, 8'd0, 32'd0);
    send_word(ACT_POP, 8'd0, 32'd0);
    drain();
    write_capacity(9'd0);
    send_word(ACT_PUSH, 8'd1, 32'd1);
    drain();
    write_capacity(9'd1);
    send_word(ACT_PUSH, 8'd1, 32'd1);
    send_word(ACT_PUSH, 8'd2, 32'd0);
    send_word(ACT_PUSH, 8'd1, 32'd0);
    drain();
    // random phases, with different idling and capacities
    write_capacity(9'd5);
    random_words(120, 15);
    drain();
    send_idle = 71;
    write_capacity(9'd511);
    random_words(130, 255);
    drain();
    send_idle = 0; stall_pct = 71;
    write_capacity(9'd256);
    for (int i = 0; i < 60; i++) send_word(ACT_PUSH, i[7:0], $urandom_range(40));
    random_words(110, 63);
    drain();
    send_idle = 36; stall_pct = 36;
    write_capacity(9'd40);
    random_words(120, 63);
    drain();
    send_idle = 0; stall_pct = 0;
    write_capacity(9'd300);
    random_words(60, 255);
    drain();
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
